### rtl/dsff_pkg.sv
// ----------------------------------------------------------------------------
// dsff_pkg
// shared widths, constants and controller/datapath handshake types for the
// duplicate suppress flood filter
// ----------------------------------------------------------------------------
package dsff_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 32;

    localparam int unsigned ID_W   = 32;
    localparam int unsigned KEY_W  = 32;
    localparam int unsigned SEQ_W  = 16;
    localparam int unsigned HOPS_W = 8;

    localparam logic [ID_W-1:0] BCAST_ID = '1;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } status_t;

endpackage

### rtl/dsff_in_if.sv
// ----------------------------------------------------------------------------
// dsff_in_if
// packet header channel: valid/ready handshake with header fields
// ----------------------------------------------------------------------------
interface dsff_in_if;
    import dsff_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   source_id;
    logic [ID_W-1:0]   dest_id;
    logic [SEQ_W-1:0]  packet_seq;
    logic [HOPS_W-1:0] hops_left;

    modport source (
        output valid,
        input  ready,
        output source_id,
        output dest_id,
        output packet_seq,
        output hops_left
    );

    modport sink (
        input  valid,
        output ready,
        input  source_id,
        input  dest_id,
        input  packet_seq,
        input  hops_left
    );

endinterface

### rtl/dsff_out_if.sv
// ----------------------------------------------------------------------------
// dsff_out_if
// filter decision channel: valid/ready handshake with result flags
// ----------------------------------------------------------------------------
interface dsff_out_if;

    logic valid;
    logic ready;
    logic is_duplicate;
    logic deliver;
    logic relay;

    modport source (
        output valid,
        input  ready,
        output is_duplicate,
        output deliver,
        output relay
    );

    modport sink (
        input  valid,
        output ready,
        input  is_duplicate,
        input  deliver,
        input  relay
    );

endinterface

### rtl/duplicate_suppress_flood_filter.sv
// ----------------------------------------------------------------------------
// duplicate_suppress_flood_filter
// flow: a header is taken while idle, the history is then scanned one entry
//   per cycle (a match ends the scan early), then a new key is committed and
//   the result is registered once the output register is free; the next
//   header is taken only after the result is loaded
// reset: node id, ring head and fill count cleared, history reads as empty
// ----------------------------------------------------------------------------
module duplicate_suppress_flood_filter #(
    parameter int unsigned HISTORY_DEPTH = dsff_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [dsff_pkg::ID_W-1:0] cfg_wr_data,
    dsff_in_if.sink                   in_item,
    dsff_out_if.source                result
);
    import dsff_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign in_item.ready = in_ready;

    dsff_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dsff_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_item),
        .result      (result),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

### rtl/dsff_ctrl.sv
// ----------------------------------------------------------------------------
// dsff_ctrl
// sequencer: takes a header, runs the history scan, then commits the key
// and hands the decision to the output register
// ----------------------------------------------------------------------------
module dsff_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dsff_pkg::status_t status,
    output dsff_pkg::cmd_t    cmd
);
    import dsff_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/dsff_dp.sv
// ----------------------------------------------------------------------------
// dsff_dp
// datapath: key forming, key history memory with fill count, scan compare,
// ring head, node id register and output register
// ----------------------------------------------------------------------------
module dsff_dp #(
    parameter int unsigned HISTORY_DEPTH = dsff_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [dsff_pkg::ID_W-1:0]  cfg_wr_data,
    dsff_in_if.sink                    in_item,
    dsff_out_if.source                 result,
    input  dsff_pkg::cmd_t             cmd,
    output dsff_pkg::status_t          status
);
    import dsff_pkg::*;

    localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [IDX_W-1:0] HEAD_LAST = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(HISTORY_DEPTH);

    logic [KEY_W-1:0]  mem [HISTORY_DEPTH];

    logic [KEY_W-1:0]  key_reg;
    logic [ID_W-1:0]   dest_reg;
    logic [HOPS_W-1:0] hops_reg;
    logic [ID_W-1:0]   local_id_reg;
    logic [KEY_W-1:0]  rdata_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              rd_pend_reg;
    logic              hit_reg;
    logic              out_valid_reg;
    logic              out_dup_reg;
    logic              out_deliver_reg;
    logic              out_relay_reg;

    logic [KEY_W-1:0]  key_in;
    logic              issue;
    logic              match;
    logic              for_us;
    logic              deliver_new;
    logic              relay_new;

    always_comb
    begin
        key_in      = in_item.source_id ^ {in_item.packet_seq, {(KEY_W - SEQ_W){1'b0}}};
        issue       = cmd.scan && !hit_reg && (idx_reg != fill_reg);
        match       = rd_pend_reg && (rdata_reg == key_reg);
        for_us      = (dest_reg == local_id_reg);
        deliver_new = for_us || (dest_reg == BCAST_ID);
        relay_new   = !for_us && (hops_reg != '0);

        status.scan_end = hit_reg || ((idx_reg == fill_reg) && !rd_pend_reg);
        status.out_free = !out_valid_reg || result.ready;
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            mem[head_reg] <= key_reg;
        end
        if (issue)
        begin
            rdata_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    // header capture and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg  <= key_in;
            dest_reg <= in_item.dest_id;
            hops_reg <= in_item.hops_left;
        end
        if (cmd.out_load)
        begin
            out_dup_reg     <= hit_reg;
            out_deliver_reg <= !hit_reg && deliver_new;
            out_relay_reg   <= !hit_reg && relay_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_id_reg  <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            idx_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                local_id_reg <= cfg_wr_data;
            end

            if (cmd.load)
            begin
                idx_reg     <= '0;
                rd_pend_reg <= 1'b0;
                hit_reg     <= 1'b0;
            end
            else
            begin
                rd_pend_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.commit && !hit_reg)
            begin
                head_reg <= (head_reg == HEAD_LAST) ? '0 : head_reg + IDX_W'(1);
                if (fill_reg != FILL_FULL)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.is_duplicate = out_dup_reg;
    assign result.deliver      = out_deliver_reg;
    assign result.relay        = out_relay_reg;

endmodule
